// ===== rtl/core/uapl_pkg.sv =====
// Shared constants and types for the ultrasonic amplitude and phase loop.
`timescale 1ns / 1ps
`default_nettype none
package uapl_pkg;

    localparam int PWM_MIN_DEF       = 0;
    localparam int PWM_MAX_DEF       = 16777215;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int ACC_W  = 24;   // PWM accumulator, holds up to PWM_MAX
    localparam int ERR_W  = 17;   // signed amplitude error
    localparam int SUM_W  = 36;   // exact PI sum
    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_TARGET   = 3'd0,
        REG_KP       = 3'd1,
        REG_KI       = 3'd2,
        REG_PF       = 3'd3,
        REG_PDIV     = 3'd4,
        REG_PSHIFT   = 3'd5,
        REG_BLIND    = 3'd6,
        REG_STARTOFF = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AMP_P,
        S_AMP_I,
        S_CLAMP,
        S_DIV1,
        S_MUL,
        S_DIV2,
        S_FIN,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/ultrasonic_amplitude_phase_loop_top.sv =====
// Amplitude PI and phase-locked frequency loop, bit-serial datapath.
// Sequence: a restart word goes straight to the output stage; a blind tick runs the PI
// shift-add and clamp; a full tick adds the current divide, the phase multiply and a
// phase divide with phase_shift extra zero bits, then the integral update and output.
// No new word is taken while one is in progress or its result waits for the output.
// Reset: rst_n async low clears state, loop state and registers (shift to 8).
`timescale 1ns / 1ps
`default_nettype none
module ultrasonic_amplitude_phase_loop_top #(
    parameter int PWM_MIN       = uapl_pkg::PWM_MIN_DEF,
    parameter int PWM_MAX       = uapl_pkg::PWM_MAX_DEF,
    parameter int FRACTION_BITS = uapl_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [uapl_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        restart,
    input  wire logic [15:0]                 amplitude_sample,
    input  wire logic signed [15:0]          phase_magnitude,
    input  wire logic                        phase_sign,
    input  wire logic [15:0]                 current_sample,
    input  wire logic [31:0]                 present_frequency,
    input  wire logic                        apply_offset,
    input  wire logic signed [31:0]          freq_offset,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [15:0]                      pwm_value,
    output logic                             frequency_valid,
    output logic [31:0]                      frequency_value
);

    localparam int ACC_W = uapl_pkg::ACC_W;
    localparam int ERR_W = uapl_pkg::ERR_W;
    localparam int SUM_W = uapl_pkg::SUM_W;
    localparam logic signed [SUM_W-1:0] MIN_S = SUM_W'(PWM_MIN);
    localparam logic signed [SUM_W-1:0] MAX_S = SUM_W'(PWM_MAX);

    // configuration
    logic [15:0] target_reg, kp_reg, ki_reg, pf_reg, pdiv_reg, blind_time_reg;
    logic [4:0]  shift_reg;
    logic [23:0] start_off_reg;
    logic        wr_en;
    logic [2:0]  widx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= '0;
            kp_reg         <= '0;
            ki_reg         <= '0;
            pf_reg         <= '0;
            pdiv_reg       <= '0;
            shift_reg      <= 5'd8;
            blind_time_reg <= '0;
            start_off_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (uapl_pkg::reg_idx_t'(widx))
                uapl_pkg::REG_TARGET:   target_reg     <= pwdata[15:0];
                uapl_pkg::REG_KP:       kp_reg         <= pwdata[15:0];
                uapl_pkg::REG_KI:       ki_reg         <= pwdata[15:0];
                uapl_pkg::REG_PF:       pf_reg         <= pwdata[15:0];
                uapl_pkg::REG_PDIV:     pdiv_reg       <= pwdata[15:0];
                uapl_pkg::REG_PSHIFT:   shift_reg      <= pwdata[4:0];
                uapl_pkg::REG_BLIND:    blind_time_reg <= pwdata[15:0];
                uapl_pkg::REG_STARTOFF: start_off_reg  <= pwdata[23:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (uapl_pkg::reg_idx_t'(widx))
            uapl_pkg::REG_TARGET:   prdata = {16'd0, target_reg};
            uapl_pkg::REG_KP:       prdata = {16'd0, kp_reg};
            uapl_pkg::REG_KI:       prdata = {16'd0, ki_reg};
            uapl_pkg::REG_PF:       prdata = {16'd0, pf_reg};
            uapl_pkg::REG_PDIV:     prdata = {16'd0, pdiv_reg};
            uapl_pkg::REG_PSHIFT:   prdata = {27'd0, shift_reg};
            uapl_pkg::REG_BLIND:    prdata = {16'd0, blind_time_reg};
            uapl_pkg::REG_STARTOFF: prdata = {8'd0, start_off_reg};
            default:                prdata = '0;
        endcase
    end

    // loop state and working registers
    uapl_pkg::state_t state_reg, state_next;
    logic [ACC_W-1:0]        accum_reg, accum_next;
    logic signed [ERR_W-1:0] last_err_reg, last_err_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [31:0]             integ_reg, integ_next;
    logic [15:0]             blind_reg, blind_next;
    logic                    run_freq_reg, run_freq_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SUM_W-1:0] op_reg, op_next;
    logic [15:0]             gain_reg, gain_next;
    logic [5:0]              cnt_reg, cnt_next;
    logic [15:0]             rem_reg, rem_next;
    logic [15:0]             dq_reg, dq_next;
    logic [31:0]             fop_reg, fop_next;
    logic [15:0]             mag_reg, mag_next;
    logic [31:0]             prod_reg, prod_next;
    logic [31:0]             q_reg, q_next;
    logic                    neg_reg, neg_next;
    logic                    fv_reg, fv_next;
    logic [31:0]             fval_reg, fval_next;
    // latched word
    logic [31:0]             pfreq_reg, pfreq_next;
    logic                    apply_reg, apply_next;
    logic [31:0]             foff_reg, foff_next;
    logic [15:0]             cur_reg, cur_next;
    // output stage
    logic                    ov_reg, ov_next;
    logic [15:0]             opwm_reg, opwm_next;
    logic                    ofv_reg, ofv_next;
    logic [31:0]             ofval_reg, ofval_next;

    logic [15:0]  pf_eff, pd_eff;
    logic [16:0]  rs;
    logic         rbit;
    logic [15:0]  dq_new;
    logic [31:0]  term;
    logic [31:0]  preload;
    logic [5:0]   div2_last;

    assign pf_eff    = (pf_reg == 16'd0) ? 16'd1 : pf_reg;
    assign pd_eff    = (pdiv_reg == 16'd0) ? 16'd1 : pdiv_reg;
    assign preload   = {{8{start_off_reg[23]}}, start_off_reg} << FRACTION_BITS;
    assign div2_last = {1'b0, shift_reg} + 6'd31;
    assign in_ready  = (state_reg == uapl_pkg::S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        accum_next    = accum_reg;
        last_err_next = last_err_reg;
        err_next      = err_reg;
        integ_next    = integ_reg;
        blind_next    = blind_reg;
        run_freq_next = run_freq_reg;
        sum_next      = sum_reg;
        op_next       = op_reg;
        gain_next     = gain_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        dq_next       = dq_reg;
        fop_next      = fop_reg;
        mag_next      = mag_reg;
        prod_next     = prod_reg;
        q_next        = q_reg;
        neg_next      = neg_reg;
        fv_next       = fv_reg;
        fval_next     = fval_reg;
        pfreq_next    = pfreq_reg;
        apply_next    = apply_reg;
        foff_next     = foff_reg;
        cur_next      = cur_reg;
        ov_next       = ov_reg && !out_ready;
        opwm_next     = opwm_reg;
        ofv_next      = ofv_reg;
        ofval_next    = ofval_reg;
        rs            = '0;
        rbit          = 1'b0;
        dq_new        = dq_reg;
        term          = q_reg;

        case (state_reg)
            uapl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    pfreq_next = present_frequency;
                    apply_next = apply_offset;
                    foff_next  = freq_offset;
                    cur_next   = current_sample;
                    // phase magnitude as unsigned, sign folded with phase_sign
                    mag_next   = phase_magnitude[15] ? 16'(-phase_magnitude)
                                                     : phase_magnitude;
                    neg_next   = phase_magnitude[15] ^ !phase_sign;
                    fv_next    = 1'b0;
                    fval_next  = '0;
                    if (restart)
                    begin
                        integ_next = preload;
                        blind_next = '0;
                        state_next = uapl_pkg::S_DONE;
                    end
                    else
                    begin
                        err_next  = $signed({1'b0, target_reg})
                                  - $signed({1'b0, amplitude_sample});
                        sum_next  = SUM_W'(accum_reg);
                        op_next   = SUM_W'($signed({1'b0, target_reg})
                                  - $signed({1'b0, amplitude_sample}));
                        gain_next = kp_reg;
                        cnt_next  = '0;
                        run_freq_next = (blind_reg >= blind_time_reg);
                        if (blind_reg < blind_time_reg)
                        begin
                            blind_next = blind_reg + 16'd1;
                        end
                        state_next = uapl_pkg::S_AMP_P;
                    end
                end
            end
            uapl_pkg::S_AMP_P, uapl_pkg::S_AMP_I:
            begin
                if (gain_reg[0])
                begin
                    sum_next = (state_reg == uapl_pkg::S_AMP_P) ? sum_reg + op_reg
                                                                 : sum_reg - op_reg;
                end
                op_next   = op_reg <<< 1;
                gain_next = gain_reg >> 1;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15)
                begin
                    cnt_next = '0;
                    if (state_reg == uapl_pkg::S_AMP_P)
                    begin
                        op_next    = SUM_W'(last_err_reg);
                        gain_next  = ki_reg;
                        state_next = uapl_pkg::S_AMP_I;
                    end
                    else
                    begin
                        state_next = uapl_pkg::S_CLAMP;
                    end
                end
            end
            uapl_pkg::S_CLAMP:
            begin
                if (sum_reg <= MIN_S)
                begin
                    accum_next = ACC_W'(PWM_MIN);
                end
                else if (sum_reg > MAX_S)
                begin
                    accum_next = ACC_W'(PWM_MAX);
                end
                else
                begin
                    accum_next = sum_reg[ACC_W-1:0];
                end
                last_err_next = err_reg;
                rem_next      = '0;
                dq_next       = cur_reg;
                cnt_next      = '0;
                state_next    = run_freq_reg ? uapl_pkg::S_DIV1 : uapl_pkg::S_DONE;
            end
            uapl_pkg::S_DIV1:
            begin
                rs   = {rem_reg, dq_reg[15]};
                rbit = (rs >= {1'b0, pf_eff});
                rem_next = rbit ? 16'(rs - {1'b0, pf_eff}) : rs[15:0];
                dq_new   = {dq_reg[14:0], rbit};
                dq_next  = dq_new;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15)
                begin
                    fop_next   = 32'(dq_new) + 32'd1;
                    prod_next  = '0;
                    cnt_next   = '0;
                    state_next = uapl_pkg::S_MUL;
                end
            end
            uapl_pkg::S_MUL:
            begin
                if (mag_reg[0])
                begin
                    prod_next = prod_reg + fop_reg;
                end
                fop_next = fop_reg << 1;
                mag_next = mag_reg >> 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15)
                begin
                    rem_next   = '0;
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = uapl_pkg::S_DIV2;
                end
            end
            uapl_pkg::S_DIV2:
            begin
                // product bits MSB first, then phase_shift zeros
                rs   = {rem_reg, prod_reg[31]};
                rbit = (rs >= {1'b0, pd_eff});
                rem_next  = rbit ? 16'(rs - {1'b0, pd_eff}) : rs[15:0];
                prod_next = prod_reg << 1;
                q_next    = {q_reg[30:0], rbit};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == div2_last)
                begin
                    state_next = uapl_pkg::S_FIN;
                end
            end
            uapl_pkg::S_FIN:
            begin
                term       = neg_reg ? (32'd0 - q_reg) : q_reg;
                integ_next = integ_reg - term;
                fv_next    = 1'b1;
                fval_next  = apply_reg
                           ? 32'($signed(integ_reg - term) >>> FRACTION_BITS) + foff_reg
                           : pfreq_reg;
                state_next = uapl_pkg::S_DONE;
            end
            uapl_pkg::S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    opwm_next  = 16'(accum_reg >> FRACTION_BITS);
                    ofv_next   = fv_reg;
                    ofval_next = fval_reg;
                    state_next = uapl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = uapl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= uapl_pkg::S_IDLE;
            accum_reg    <= '0;
            last_err_reg <= '0;
            integ_reg    <= '0;
            blind_reg    <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            accum_reg    <= accum_next;
            last_err_reg <= last_err_next;
            integ_reg    <= integ_next;
            blind_reg    <= blind_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg      <= err_next;
        run_freq_reg <= run_freq_next;
        sum_reg      <= sum_next;
        op_reg       <= op_next;
        gain_reg     <= gain_next;
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        fop_reg      <= fop_next;
        mag_reg      <= mag_next;
        prod_reg     <= prod_next;
        q_reg        <= q_next;
        neg_reg      <= neg_next;
        fv_reg       <= fv_next;
        fval_reg     <= fval_next;
        pfreq_reg    <= pfreq_next;
        apply_reg    <= apply_next;
        foff_reg     <= foff_next;
        cur_reg      <= cur_next;
        opwm_reg     <= opwm_next;
        ofv_reg      <= ofv_next;
        ofval_reg    <= ofval_next;
    end

    assign out_valid       = ov_reg;
    assign pwm_value       = opwm_reg;
    assign frequency_valid = ofv_reg;
    assign frequency_value = ofval_reg;

    a_restart_preload: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && restart |=> integ_reg == $past(preload))
        else $error("integral not preloaded on restart");

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != uapl_pkg::S_IDLE |-> !in_ready)
        else $error("input taken while busy");

    a_div2_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == uapl_pkg::S_DIV2 |-> cnt_reg <= div2_last)
        else $error("phase divide overran");

    a_blind_no_freq: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == uapl_pkg::S_CLAMP && !run_freq_reg |=> state_reg == uapl_pkg::S_DONE)
        else $error("frequency loop ran during blind time");

endmodule
`default_nettype wire
